/* design/sicf_pkg.sv */
// ----------------------------------------------------------------------------
// sicf_pkg
// Shared types, register codes and helpers for the spherical indenter block.
// ----------------------------------------------------------------------------
package sicf_pkg;

  // multiplier operand width
  localparam int MUL_W = 36;

  // largest force magnitude before projection
  localparam logic [46:0] FMAG_MAX = {47{1'b1}};

  // register indexes
  localparam logic [2:0] REG_STIFFNESS = 3'd0;
  localparam logic [2:0] REG_RADIUS    = 3'd1;
  localparam logic [2:0] REG_CENTER_X  = 3'd2;
  localparam logic [2:0] REG_CENTER_Y  = 3'd3;
  localparam logic [2:0] REG_CENTER_Z  = 3'd4;
  localparam logic [2:0] REG_GROUP     = 3'd5;

  typedef struct packed {
    logic        [31:0] stiffness;
    logic        [30:0] radius;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [31:0] group_select;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               has_mass;
    logic        [31:0] group_bits;
    logic signed [31:0] stress_yx;
    logic signed [31:0] stress_yy;
    logic signed [31:0] stress_yz;
    logic        [31:0] volume;
    logic               last_particle;
  } particle_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               in_contact;
    logic signed [63:0] total_x;
    logic signed [63:0] total_y;
    logic signed [63:0] total_z;
    logic signed [63:0] stress_total;
    logic               pass_done;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCREEN, ST_SQ, ST_CMP, ST_SQRT, ST_FMAG, ST_DIV_GO, ST_DIV_WAIT,
    ST_FPROJ, ST_DOT, ST_CBRT_GO, ST_CBRT_WAIT, ST_WGT, ST_ACC, ST_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    OP_SQRT, OP_DIV, OP_CBRT
  } root_op_t;

  // request to the iterative root / divide unit
  typedef struct packed {
    logic        start;
    root_op_t    op;
    logic [63:0] arg;
  } root_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } root_rsp_t;

  // signed 64-bit add that clamps at the range limits
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

/* design/spherical_indenter_contact_force.sv */
// ----------------------------------------------------------------------------
// spherical_indenter_contact_force
// Penalty contact force of a spherical indenter on a stream of particles.
// ----------------------------------------------------------------------------
// Particles arrive on the particle channel (valid/ready); each transaction
// gives exactly one transaction on the result channel (valid/ready).
// Configuration must be written over the APB port only while the block is
// idle; the block itself does not enforce this. One particle is processed
// at a time; particle_ready is high only when the sequencer is idle. A
// particle that is unselected or outside the box ends after screening; one
// in the box but not strictly inside the sphere, or exactly at its centre,
// ends after the squares are compared; one in contact takes a square root,
// three divisions for the normal and a cube root in the shared iterative
// unit, plus screening and steps through the single shared multiplier. No
// new particle is taken until the result of the last one is registered.
// Force totals and the stress sum accumulate over a pass and are reported
// with the particle that carries last_particle, then cleared.
// Reset clears the configuration, the sequencer, the totals and the result
// valid flag. A result waits in the output register while result_ready is
// low; the sequencer holds in its final state until that register is free.
// ----------------------------------------------------------------------------
module spherical_indenter_contact_force import sicf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        particle_valid,
  output logic        particle_ready,
  input  particle_t   particle,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  cfg_t       cfg;
  seq_state_t state, state_next;
  root_req_t  root_req;
  root_rsp_t  root_rsp;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // per-particle registers
  logic signed [32:0] d [3];
  logic        [30:0] a_mag [3];
  logic               neg [3];
  logic signed [31:0] stress [3];
  logic        [16:0] nm [3];
  logic signed [47:0] f [3];
  logic        [31:0] vol;
  logic               sel;
  logic               last_q;
  logic               contact;
  logic        [2:0]  k;
  logic        [63:0] s_sum;
  logic        [61:0] rsq;
  logic        [30:0] r;
  logic        [30:0] dr;
  logic        [45:0] dr2;
  logic        [61:0] fhi_acc;
  logic        [46:0] fmag;
  logic        [48:0] plo;
  logic signed [50:0] dot;
  logic        [21:0] cval;
  logic signed [63:0] term;

  // running totals
  logic signed [63:0] sum_x, sum_y, sum_z, sum_s;

  // combinational helpers
  logic               inbox;
  logic               sq_lt;
  logic               fin_ok;
  logic        [2:0]  idx;
  logic        [63:0] proj_prod;
  logic        [47:0] proj_mag;
  logic        [62:0] fmag_sum;
  logic signed [17:0] n_cur;
  logic signed [33:0] rad_s;
  logic signed [33:0] dd [3];

  sicf_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sicf_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));

  sicf_root u_root (.clk, .rst, .req(root_req), .rsp(root_rsp));

  always_comb begin
    rad_s = $signed({3'b000, cfg.radius});
    for (int i = 0; i < 3; i++) begin
      dd[i] = {d[i][32], d[i]};
    end
    inbox = 1'b1;
    for (int i = 0; i < 3; i++) begin
      inbox = inbox && (dd[i] < rad_s) && (dd[i] > -rad_s);
    end
    sq_lt     = s_sum < {2'b0, rsq};
    fin_ok    = !result_valid || result_ready;
    idx       = k - 3'd1;
    proj_prod = {mul_p[31:0], 32'b0} + {15'b0, plo};
    proj_mag  = proj_prod[63:16];
    fmag_sum  = {1'b0, fhi_acc} + {15'b0, mul_p[63:16]};
    n_cur     = neg[k[1:0]] ? -$signed({1'b0, nm[k[1:0]]}) : $signed({1'b0, nm[k[1:0]]});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (particle_valid) state_next = ST_SCREEN;
      ST_SCREEN:    state_next = (sel && inbox) ? ST_SQ : ST_FINISH;
      ST_SQ:        if (k == 3'd4) state_next = ST_CMP;
      ST_CMP:       state_next = (sq_lt && s_sum != 64'd0) ? ST_SQRT : ST_FINISH;
      ST_SQRT:      if (root_rsp.done) state_next = ST_FMAG;
      ST_FMAG:      if (k == 3'd3) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (root_rsp.done) state_next = (k == 3'd2) ? ST_FPROJ : ST_DIV_GO;
      ST_FPROJ:     if (k == 3'd6) state_next = ST_DOT;
      ST_DOT:       if (k == 3'd3) state_next = ST_CBRT_GO;
      ST_CBRT_GO:   state_next = ST_CBRT_WAIT;
      ST_CBRT_WAIT: if (root_rsp.done) state_next = ST_WGT;
      ST_WGT:       if (k == 3'd2) state_next = ST_ACC;
      ST_ACC:       state_next = ST_FINISH;
      ST_FINISH:    if (fin_ok) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, root requests, handshake
  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    root_req.start = 1'b0;
    root_req.op    = OP_SQRT;
    root_req.arg   = s_sum;
    particle_ready = (state == ST_IDLE);
    unique case (state)
      ST_SQ: begin
        if (k < 3'd3) begin
          mul_a = {5'b0, a_mag[k[1:0]]};
          mul_b = {5'b0, a_mag[k[1:0]]};
        end else begin
          mul_a = {5'b0, cfg.radius};
          mul_b = {5'b0, cfg.radius};
        end
      end
      ST_CMP: root_req.start = sq_lt && s_sum != 64'd0;
      ST_FMAG: begin
        priority case (k)
          3'd0: begin
            mul_a = {5'b0, dr};
            mul_b = {5'b0, dr};
          end
          3'd1: begin
            mul_a = {4'b0, cfg.stiffness};
            mul_b = {6'b0, mul_p[61:32]};
          end
          default: begin
            mul_a = {4'b0, cfg.stiffness};
            mul_b = {20'b0, dr2[15:0]};
          end
        endcase
      end
      ST_DIV_GO: begin
        root_req.start = 1'b1;
        root_req.op    = OP_DIV;
        root_req.arg   = {2'b0, r, a_mag[k[1:0]]};
      end
      ST_FPROJ: begin
        mul_b = {19'b0, nm[k[2:1]]};
        mul_a = k[0] ? {21'b0, fmag[46:32]} : {4'b0, fmag[31:0]};
      end
      ST_DOT: begin
        mul_a = {{4{stress[k[1:0]][31]}}, stress[k[1:0]]};
        mul_b = {{18{n_cur[17]}}, n_cur};
      end
      ST_CBRT_GO: begin
        root_req.start = 1'b1;
        root_req.op    = OP_CBRT;
        root_req.arg   = {vol, 32'b0};
      end
      ST_WGT: begin
        if (k == 3'd0) begin
          mul_a = {14'b0, cval};
          mul_b = {14'b0, cval};
        end else begin
          mul_a = {dot[50], dot[50:16]};
          mul_b = {8'b0, mul_p[43:16]};
        end
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-particle datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (particle_valid) begin
          d[0]      <= $signed({particle.pos_x[31], particle.pos_x})
                     - $signed({cfg.center_x[31], cfg.center_x});
          d[1]      <= $signed({particle.pos_y[31], particle.pos_y})
                     - $signed({cfg.center_y[31], cfg.center_y});
          d[2]      <= $signed({particle.pos_z[31], particle.pos_z})
                     - $signed({cfg.center_z[31], cfg.center_z});
          stress[0] <= particle.stress_yx;
          stress[1] <= particle.stress_yy;
          stress[2] <= particle.stress_yz;
          vol       <= particle.volume;
          last_q    <= particle.last_particle;
          sel       <= particle.has_mass &&
                       ((particle.group_bits & cfg.group_select) != 32'd0);
          contact   <= 1'b0;
          for (int i = 0; i < 3; i++) f[i] <= '0;
        end
      end
      ST_SCREEN: begin
        for (int i = 0; i < 3; i++) begin
          neg[i]   <= d[i][32];
          a_mag[i] <= d[i][32] ? 31'(-d[i]) : d[i][30:0];
        end
        s_sum <= 64'd0;
        dot   <= '0;
        k     <= 3'd0;
      end
      ST_SQ: begin
        k <= (k == 3'd4) ? 3'd0 : k + 3'd1;
        if (k != 3'd0) begin
          if (idx == 3'd3) rsq <= mul_p[61:0];
          else s_sum <= s_sum + mul_p[63:0];
        end
      end
      ST_CMP: contact <= sq_lt;
      ST_SQRT: begin
        if (root_rsp.done) begin
          r  <= root_rsp.res[30:0];
          dr <= cfg.radius - root_rsp.res[30:0];
        end
      end
      ST_FMAG: begin
        k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
        priority case (k)
          3'd1: dr2 <= mul_p[61:16];
          3'd2: fhi_acc <= mul_p[61:0];
          3'd3: fmag <= (fmag_sum > {16'b0, FMAG_MAX}) ? FMAG_MAX : fmag_sum[46:0];
          default: ;
        endcase
      end
      ST_DIV_WAIT: begin
        if (root_rsp.done) begin
          nm[k[1:0]] <= root_rsp.res[16:0];
          k          <= (k == 3'd2) ? 3'd0 : k + 3'd1;
        end
      end
      ST_FPROJ: begin
        k <= (k == 3'd6) ? 3'd0 : k + 3'd1;
        if (k != 3'd0) begin
          if (!idx[0]) begin
            plo <= mul_p[48:0];
          end else begin
            f[idx[2:1]] <= neg[idx[2:1]] ? -$signed(proj_mag) : $signed(proj_mag);
          end
        end
      end
      ST_DOT: begin
        k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
        if (k != 3'd0) dot <= dot + mul_p[50:0];
      end
      ST_CBRT_WAIT: begin
        if (root_rsp.done) cval <= root_rsp.res[21:0];
      end
      ST_WGT: begin
        k <= (k == 3'd2) ? 3'd0 : k + 3'd1;
        if (k == 3'd2) term <= {{8{mul_p[71]}}, mul_p[71:16]};
      end
      default: ;
    endcase
  end

  // pass totals
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      sum_s <= '0;
    end else if (state == ST_ACC) begin
      sum_x <= sat_add64(sum_x, 64'(f[0]));
      sum_y <= sat_add64(sum_y, 64'(f[1]));
      sum_z <= sat_add64(sum_z, 64'(f[2]));
      sum_s <= sat_add64(sum_s, term);
    end else if (state == ST_FINISH && fin_ok && last_q) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      sum_s <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && fin_ok) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && fin_ok) begin
      result.force_x      <= f[0];
      result.force_y      <= f[1];
      result.force_z      <= f[2];
      result.in_contact   <= contact;
      result.total_x      <= last_q ? sum_x : '0;
      result.total_y      <= last_q ? sum_y : '0;
      result.total_z      <= last_q ? sum_z : '0;
      result.stress_total <= last_q ? sum_s : '0;
      result.pass_done    <= last_q;
    end
  end

  // an accepted transaction always starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (rst)
    particle_valid && particle_ready |=> state != ST_IDLE)
    else $error("sequencer did not leave idle");

  // totals only accumulate for a particle in contact
  a_acc_contact: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> contact) else $error("accumulate without contact");

  // totals are cleared once reported
  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && fin_ok && last_q |=>
      sum_x == 64'sd0 && sum_y == 64'sd0 && sum_z == 64'sd0 && sum_s == 64'sd0)
    else $error("totals not cleared after pass");

endmodule

/* design/sicf_mul.sv */
// ----------------------------------------------------------------------------
// sicf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sicf_mul import sicf_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_W-1:0]    a,
  input  logic signed [MUL_W-1:0]    b,
  output logic signed [2*MUL_W-1:0]  p
);

  // one product per cycle, visible the cycle after issue
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* design/sicf_root.sv */
// ----------------------------------------------------------------------------
// sicf_root
// Iterative unit: square root, short division and cube root, one step a cycle.
// ----------------------------------------------------------------------------
module sicf_root import sicf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  root_req_t req,
  output root_rsp_t rsp
);

  logic        busy;
  logic        done;
  root_op_t    op;
  logic [4:0]  cnt;
  logic [65:0] src;
  logic [63:0] bitv;
  logic [63:0] res;
  logic [49:0] rem;
  logic [45:0] ysq;
  logic [30:0] den;

  // step terms
  logic [63:0] sq_t;
  logic [31:0] dv_r2;
  logic [49:0] cb_y2;
  logic [49:0] cb_ysq2;
  logic [49:0] cb_b;
  logic [49:0] cb_r3;

  always_comb begin
    sq_t    = res + bitv;
    dv_r2   = {rem[30:0], src[16]};
    cb_y2   = {27'b0, res[21:0], 1'b0};
    cb_ysq2 = {2'b0, ysq, 2'b0};
    cb_b    = ((cb_ysq2 + cb_y2) << 1) + (cb_ysq2 + cb_y2) + 50'd1;
    cb_r3   = {rem[46:0], src[65:63]};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      res <= 64'd0;
      ysq <= 46'd0;
      unique case (req.op)
        OP_SQRT: begin
          src  <= {2'b0, req.arg};
          bitv <= 64'd1 << 62;
          rem  <= 50'd0;
          cnt  <= 5'd31;
        end
        OP_DIV: begin
          den  <= req.arg[61:31];
          rem  <= {20'b0, req.arg[30:1]};
          src  <= {49'b0, req.arg[0], 16'b0};
          cnt  <= 5'd16;
        end
        OP_CBRT: begin
          src  <= {2'b0, req.arg};
          rem  <= 50'd0;
          cnt  <= 5'd21;
        end
        default: begin
          src  <= 66'd0;
          rem  <= 50'd0;
          cnt  <= 5'd0;
        end
      endcase
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      unique case (op)
        OP_SQRT: begin
          if (src[63:0] >= sq_t) begin
            src <= {2'b0, src[63:0] - sq_t};
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
        OP_DIV: begin
          if (dv_r2 >= {1'b0, den}) begin
            rem <= {18'b0, dv_r2 - {1'b0, den}};
            res <= {res[62:0], 1'b1};
          end else begin
            rem <= {18'b0, dv_r2};
            res <= {res[62:0], 1'b0};
          end
          src <= src << 1;
        end
        OP_CBRT: begin
          if (cb_r3 >= cb_b) begin
            rem <= cb_r3 - cb_b;
            res <= {14'b0, cb_y2 + 50'd1};
            ysq <= 46'(cb_ysq2 + (cb_y2 << 1) + 50'd1);
          end else begin
            rem <= cb_r3;
            res <= {14'b0, cb_y2};
            ysq <= cb_ysq2[45:0];
          end
          src <= src << 3;
        end
        default: begin
          res <= 64'd0;
        end
      endcase
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.res  = res[31:0];

  // sequencer never restarts a running operation
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("root unit started while busy");

  // completion is a single pulse, raised as the unit goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done)) else $error("root done while busy");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("root finished without done");

endmodule

/* design/sicf_apb.sv */
// ----------------------------------------------------------------------------
// sicf_apb
// APB register file holding stiffness, radius, centre and group mask.
// ----------------------------------------------------------------------------
module sicf_apb import sicf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_STIFFNESS: cfg.stiffness    <= pwdata;
        REG_RADIUS:    cfg.radius       <= pwdata[30:0];
        REG_CENTER_X:  cfg.center_x     <= pwdata;
        REG_CENTER_Y:  cfg.center_y     <= pwdata;
        REG_CENTER_Z:  cfg.center_z     <= pwdata;
        REG_GROUP:     cfg.group_select <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      REG_STIFFNESS: prdata = cfg.stiffness;
      REG_RADIUS:    prdata = {1'b0, cfg.radius};
      REG_CENTER_X:  prdata = cfg.center_x;
      REG_CENTER_Y:  prdata = cfg.center_y;
      REG_CENTER_Z:  prdata = cfg.center_z;
      REG_GROUP:     prdata = cfg.group_select;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* tb/sv/spherical_indenter_contact_force_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spherical_indenter_contact_force_tb
// Self-checking bench for the spherical indenter contact force block.
// ----------------------------------------------------------------------------
// Particles are streamed through the block under several indenter settings.
// A bit-exact contact force model predicts every result, and each result is
// compared field by field with the oldest prediction. Both channels idle in
// random bursts, except in the closing part of the run.
// ----------------------------------------------------------------------------
module spherical_indenter_contact_force_tb;
  import sicf_pkg::*;

  localparam int          CYCLE_LIMIT   = 2000000;
  localparam logic [2:0]  REG_UNUSED    = 3'd6;
  localparam logic [31:0] ONE_Q16       = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        particle_valid = 1'b0;
  logic        particle_ready;
  particle_t   particle = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;

  // indenter settings and running totals as the model sees them
  logic [31:0]          k_stiff;
  logic [30:0]          r_sphere;
  longint               cen_x, cen_y, cen_z;
  logic [31:0]          grp_mask;
  longint               acc_fx, acc_fy, acc_fz, acc_stress;

  result_t              pending_results[$];
  bit                   idle_on = 1'b1;
  int                   mismatches = 0;
  int                   cycles = 0;
  int                   rdy_stall = 0;

  spherical_indenter_contact_force i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .particle_valid, .particle_ready, .particle, .result_valid, .result_ready,
    .result
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // contact force model
  // ---------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned int_cbrt(longint unsigned x);
    longint unsigned y, b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b) return {1'b1, 63'b0};
    return a + b;
  endfunction

  function automatic result_t contact_force(particle_t p);
    result_t         res;
    longint          d[3], f[3], nrm[3], rr, dotv, s_dot, w, term;
    longint unsigned a[3], sq, r, dr, dr2, fmag, nm, fm, c;
    logic [63:0]     vol_arg;
    res = '0;
    rr = longint'(r_sphere);
    d[0] = longint'($signed(p.pos_x)) - cen_x;
    d[1] = longint'($signed(p.pos_y)) - cen_y;
    d[2] = longint'($signed(p.pos_z)) - cen_z;
    for (int i = 0; i < 3; i++) f[i] = 0;
    if (p.has_mass && (p.group_bits & grp_mask) != 0 &&
        d[0] < rr && d[0] > -rr && d[1] < rr && d[1] > -rr &&
        d[2] < rr && d[2] > -rr) begin
      for (int i = 0; i < 3; i++) a[i] = (d[i] < 0) ? -d[i] : d[i];
      sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (sq < longint'(r_sphere) * longint'(r_sphere)) begin
        res.in_contact = 1'b1;
        // exact centre hit gives no force
        if (sq != 0) begin
          r = int_sqrt(sq);
          dr = longint'(r_sphere) - r;
          dr2 = (dr * dr) >> 16;
          fmag = k_stiff * (dr2 >> 16) + ((k_stiff * (dr2 & 64'hFFFF)) >> 16);
          if (fmag > 64'h7FFF_FFFF_FFFF) fmag = 64'h7FFF_FFFF_FFFF;
          for (int i = 0; i < 3; i++) begin
            nm = (a[i] << 16) / r;
            fm = (fmag * nm) >> 16;
            nrm[i] = (d[i] < 0) ? -longint'(nm) : longint'(nm);
            f[i] = (d[i] < 0) ? -longint'(fm) : longint'(fm);
          end
          dotv = longint'($signed(p.stress_yx)) * nrm[0] +
                 longint'($signed(p.stress_yy)) * nrm[1] +
                 longint'($signed(p.stress_yz)) * nrm[2];
          s_dot = dotv >>> 16;
          vol_arg = {p.volume, 32'b0};
          c = int_cbrt(vol_arg);
          w = longint'((c * c) >> 16);
          term = (s_dot * w) >>> 16;
          acc_stress = clamp_add(acc_stress, term);
          acc_fx = clamp_add(acc_fx, f[0]);
          acc_fy = clamp_add(acc_fy, f[1]);
          acc_fz = clamp_add(acc_fz, f[2]);
        end
      end
    end
    res.force_x = f[0][47:0];
    res.force_y = f[1][47:0];
    res.force_z = f[2][47:0];
    if (p.last_particle) begin
      res.total_x = acc_fx;
      res.total_y = acc_fy;
      res.total_z = acc_fz;
      res.stress_total = acc_stress;
      res.pass_done = 1'b1;
      acc_fx = 0;
      acc_fy = 0;
      acc_fz = 0;
      acc_stress = 0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      result_ready <= 1'b1;
      rdy_stall <= 0;
    end else if (rdy_stall > 0) begin
      result_ready <= 1'b0;
      rdy_stall <= rdy_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_ready <= 1'b0;
      rdy_stall <= $urandom_range(0, 13);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got, ref bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    bit      bad;
    if (!rst && result_valid && result_ready) begin
      bad = 1'b0;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("mismatch: result transaction with none expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("force_x", 64'(want.force_x), 64'(result.force_x), bad);
        check_field("force_y", 64'(want.force_y), 64'(result.force_y), bad);
        check_field("force_z", 64'(want.force_z), 64'(result.force_z), bad);
        check_field("in_contact", 64'(want.in_contact), 64'(result.in_contact), bad);
        check_field("total_x", want.total_x, result.total_x, bad);
        check_field("total_y", want.total_y, result.total_y, bad);
        check_field("total_z", want.total_z, result.total_z, bad);
        check_field("stress_total", want.stress_total, result.stress_total, bad);
        check_field("pass_done", 64'(want.pass_done), 64'(result.pass_done), bad);
        if (bad) mismatches++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // particle side and register port
  // ---------------------------------------------------------------------------
  task automatic send_particle(particle_t p);
    particle <= p;
    particle_valid <= 1'b1;
    do @(posedge clk); while (!particle_ready);
    pending_results.push_back(contact_force(p));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      particle_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    particle_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STIFFNESS: k_stiff = val;
      REG_RADIUS:    r_sphere = val[30:0];
      REG_CENTER_X:  cen_x = longint'($signed(val));
      REG_CENTER_Y:  cen_y = longint'($signed(val));
      REG_CENTER_Z:  cen_z = longint'($signed(val));
      REG_GROUP:     grp_mask = val;
      default: ;
    endcase
  endtask

  task automatic set_indenter(logic [31:0] k, logic [30:0] rad, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] cz, logic [31:0] grp);
    reg_write(REG_STIFFNESS, k);
    reg_write(REG_RADIUS, {1'b0, rad});
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_CENTER_Z, cz);
    reg_write(REG_GROUP, grp);
  endtask

  function automatic particle_t rand_particle();
    particle_t p;
    p.pos_x = $urandom();
    p.pos_y = $urandom();
    p.pos_z = $urandom();
    p.has_mass = $urandom_range(0, 1);
    p.group_bits = $urandom();
    p.stress_yx = $urandom();
    p.stress_yy = $urandom();
    p.stress_yz = $urandom();
    p.volume = $urandom();
    p.last_particle = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // particle placed around the sphere, mostly selected
  function automatic particle_t near_particle();
    particle_t p;
    longint    span;
    p = rand_particle();
    span = (longint'(r_sphere) * 5) / 4 + 1;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    p.pos_x = 32'(cen_x + longint'($urandom_range(0, 2 * span)) - span);
    p.pos_y = 32'(cen_y + longint'($urandom_range(0, 2 * span)) - span);
    p.pos_z = 32'(cen_z + longint'($urandom_range(0, 2 * span)) - span);
    if ($urandom_range(0, 9) != 0) p.has_mass = 1'b1;
    if ($urandom_range(0, 9) != 0) p.group_bits = p.group_bits | grp_mask;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    particle_t base, p;
    set_indenter(32'h0002_0000, 31'h0010_0000, ONE_Q16, -32'sd131072, 32'h0003_0000,
                 32'h0000_00F0);
    base = '0;
    base.has_mass = 1'b1;
    base.group_bits = 32'h0000_0010;
    base.stress_yx = 32'h0001_8000;
    base.stress_yy = -32'sd65536;
    base.stress_yz = 32'h0000_4000;
    base.volume = 32'h0008_0000;
    // zero distance
    p = base; p.pos_x = ONE_Q16; p.pos_y = -32'sd131072; p.pos_z = 32'h0003_0000;
    send_particle(p);
    // inside along +x and -y
    p.pos_x = 32'h0005_0000; send_particle(p);
    p.pos_x = ONE_Q16; p.pos_y = -32'sd600000; send_particle(p);
    // on the surface, outside the box, corner of the box outside the sphere
    p.pos_y = -32'sd131072; p.pos_x = 32'h0011_0000; send_particle(p);
    p.pos_x = 32'h7FFF_FFFF; send_particle(p);
    p.pos_x = 32'h000E_0000; p.pos_y = 32'h000C_0000; p.pos_z = 32'h000F_0000;
    send_particle(p);
    // unselected: no mass, foreign group
    p = base; p.pos_x = 32'h0003_0000; p.has_mass = 1'b0; send_particle(p);
    p.has_mass = 1'b1; p.group_bits = 32'hFFFF_FF0F; send_particle(p);
    // stress and volume extremes, then close the pass
    p = base; p.pos_z = 32'h0008_0000;
    p.stress_yx = 32'h7FFF_FFFF; p.stress_yy = 32'h8000_0000; p.stress_yz = 32'h8000_0000;
    p.volume = 32'hFFFF_FFFF; send_particle(p);
    p.volume = 32'h0; p.stress_yz = 32'h7FFF_FFFF; p.last_particle = 1'b1;
    send_particle(p);
    // writes to an unused index leave the settings alone
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    p = base; p.pos_x = 32'h0004_0000; p.last_particle = 1'b1; send_particle(p);
    // huge force saturates, widest sphere and extreme centre
    set_indenter(32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    p = base; p.pos_x = 32'h0000_0001; p.pos_y = -32'sd1; send_particle(p);
    p.pos_x = 32'h7FFF_FFFF; send_particle(p);
    p.pos_x = 32'h8000_0000; p.pos_y = 32'h8000_0000; p.pos_z = 32'h8000_0000;
    p.last_particle = 1'b1; send_particle(p);
    reg_write(REG_CENTER_X, 32'h8000_0000);
    reg_write(REG_CENTER_Z, 32'h7FFF_FFFF);
    p = base; p.pos_x = 32'h8000_0001; p.pos_z = 32'h7FFF_0000; p.last_particle = 1'b1;
    send_particle(p);
    // zero radius never touches
    set_indenter(32'hFFFF_FFFF, 31'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    p = base; p.group_bits = 32'hFFFF_FFFF; p.last_particle = 1'b1; send_particle(p);
  endtask

  task automatic test_random_pass(int n);
    particle_t p;
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(0, 7) == 0) ? rand_particle() : near_particle();
      send_particle(p);
    end
  endtask

  task automatic test_random_settings(int rounds, int n);
    for (int j = 0; j < rounds; j++) begin
      set_indenter($urandom(), 31'($urandom_range(1, 1 << ($urandom_range(4, 30)))),
                   $urandom(), $urandom(), $urandom(),
                   $urandom() | (32'd1 << $urandom_range(0, 31)));
      test_random_pass(n);
    end
  endtask

  initial begin
    k_stiff = '0; r_sphere = '0; cen_x = 0; cen_y = 0; cen_z = 0; grp_mask = '0;
    acc_fx = 0; acc_fy = 0; acc_fz = 0; acc_stress = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // everyday indenter, then a stiff one, a tiny one and random settings
    set_indenter(32'h0010_0000, 31'h0020_0000, 32'h0100_0000, 32'hFF00_0000,
                 32'h0, 32'h0000_FFFF);
    test_random_pass(300);
    set_indenter(32'hFFFF_FFFF, 31'h4000_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    test_random_pass(200);
    set_indenter(32'h0000_0001, 31'h0000_0100, 32'h7FFF_FF00, 32'h8000_0100,
                 32'h0, 32'h8000_0000);
    test_random_pass(150);
    test_random_settings(4, 200);
    // closing part without idling
    idle_on = 1'b0;
    test_random_settings(1, 180);
    particle_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
